@@ src/bootp_vendor_option_parser_unit_assert.svh @@
// assertion macros shared by the parser modules
`ifndef BOOTP_VENDOR_OPTION_PARSER_UNIT_ASSERT_SVH
`define BOOTP_VENDOR_OPTION_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define BVOP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define BVOP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define BVOP_ASSERT(label, clk, rst, prop)
`define BVOP_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

@@ src/bvop_pkg.sv @@
`default_nettype none

package bvop_pkg;

   // result kinds
   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_SUBNET   = 3'd1;
   localparam logic [2:0] KIND_CLASSFUL = 3'd2;
   localparam logic [2:0] KIND_MISMATCH = 3'd3;
   localparam logic [2:0] KIND_END      = 3'd4;
   localparam logic [2:0] KIND_TRUNC    = 3'd5;

   // option tags
   localparam logic [7:0] TAG_PAD    = 8'd0;
   localparam logic [7:0] TAG_SUBNET = 8'd1;
   localparam logic [7:0] TAG_END    = 8'd255;

   localparam logic [7:0] COOKIE_BYTES [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tag;
      logic [7:0]  len;
      logic [7:0]  offset;
      logic [7:0]  data;
      logic        done;
      logic [31:0] mask;
   } result_type;

   // all results caused by one input item
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [SLOT_W-1:0]            count;
      logic [31:0]                  addr;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/bvop_front.sv @@
`default_nettype none
`include "bootp_vendor_option_parser_unit_assert.svh"

module bvop_front
   import bvop_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_first_byte,
   input  logic             req_final_byte,
   input  logic [31:0]      req_own_address,
   input  queue_status_type q_status,
   output push_type         push
);

   localparam logic [2:0] PH_COOKIE  = 3'd0;
   localparam logic [2:0] PH_TAG     = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_DATA    = 3'd3;
   localparam logic [2:0] PH_STOPPED = 3'd4;
   localparam logic [2:0] PH_IDLE    = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  cidx_ff, cidx_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  off_ff, off_in;
   logic [31:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;

   logic [2:0]  ph;
   logic [1:0]  ci;
   logic [7:0]  tg, ln, of;
   logic [31:0] ac;
   logic        sn;
   logic        done;
   logic        accept;

   result_type  res_a, res_b, res_c, res_d;
   logic        a_v, b_v, c_v, d_v;
   bundle_type  bundle;
   logic [SLOT_W-1:0] n;

   assign accept    = req_valid && !q_status.full;
   assign req_stall = q_status.full;

   always_comb begin
      // a new area restarts everything before the byte is handled
      ph = req_first_byte ? PH_COOKIE : phase_ff;
      ci = req_first_byte ? 2'd0 : cidx_ff;
      tg = req_first_byte ? 8'd0 : tag_ff;
      ln = req_first_byte ? 8'd0 : len_ff;
      of = req_first_byte ? 8'd0 : off_ff;
      ac = req_first_byte ? 32'd0 : acc_ff;
      sn = req_first_byte ? 1'b0 : seen_ff;

      phase_in = ph;
      cidx_in  = ci;
      tag_in   = tg;
      len_in   = ln;
      off_in   = of;
      acc_in   = ac;
      seen_in  = sn;
      done     = 1'b0;

      res_a = '0;
      res_b = '0;
      res_c = '0;
      res_d = '0;
      a_v   = 1'b0;
      b_v   = 1'b0;
      c_v   = 1'b0;
      d_v   = 1'b0;

      unique case (ph)
         PH_COOKIE: begin
            if (req_data_byte != COOKIE_BYTES[ci]) begin
               a_v          = 1'b1;
               res_a.kind   = KIND_MISMATCH;
               res_a.offset = {6'd0, ci};
               res_a.data   = req_data_byte;
               phase_in     = PH_STOPPED;
            end else if (ci == 2'd3) begin
               cidx_in  = 2'd0;
               phase_in = PH_TAG;
            end else begin
               cidx_in = ci + 2'd1;
            end
         end
         PH_TAG: begin
            if (req_data_byte == TAG_END) begin
               a_v        = 1'b1;
               res_a.kind = KIND_END;
               res_a.tag  = TAG_END;
               phase_in   = PH_STOPPED;
            end else if (req_data_byte != TAG_PAD) begin
               tag_in   = req_data_byte;
               len_in   = 8'd0;
               off_in   = 8'd0;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            len_in   = req_data_byte;
            off_in   = 8'd0;
            acc_in   = 32'd0;
            phase_in = (req_data_byte == 8'd0) ? PH_TAG : PH_DATA;
         end
         PH_DATA: begin
            done         = ({1'b0, of} + 9'd1) == {1'b0, ln};
            a_v          = 1'b1;
            res_a.kind   = KIND_DATA;
            res_a.tag    = tg;
            res_a.len    = ln;
            res_a.offset = of;
            res_a.data   = req_data_byte;
            res_a.done   = done;
            if (tg == TAG_SUBNET && of < 8'd4) begin
               acc_in = {ac[23:0], req_data_byte};
            end
            if (done) begin
               if (tg == TAG_SUBNET && ln >= 8'd4) begin
                  b_v        = 1'b1;
                  res_b.kind = KIND_SUBNET;
                  res_b.tag  = TAG_SUBNET;
                  res_b.len  = ln;
                  res_b.mask = acc_in;
                  seen_in    = 1'b1;
               end
               phase_in = PH_TAG;
            end else begin
               off_in = of + 8'd1;
            end
         end
         default: ;
      endcase

      if (req_final_byte && ph != PH_IDLE) begin
         if (phase_in == PH_COOKIE) begin
            c_v        = 1'b1;
            res_c.kind = KIND_TRUNC;
         end else if (phase_in == PH_LEN) begin
            c_v        = 1'b1;
            res_c.kind = KIND_TRUNC;
            res_c.tag  = tag_in;
         end else if (phase_in == PH_DATA) begin
            c_v          = 1'b1;
            res_c.kind   = KIND_TRUNC;
            res_c.tag    = tag_in;
            res_c.len    = len_in;
            res_c.offset = off_in;
         end
         if (!seen_in) begin
            d_v        = 1'b1;
            res_d.kind = KIND_CLASSFUL;
            if (!req_own_address[31]) begin
               res_d.mask = 32'hFF00_0000;
            end else if (!req_own_address[30]) begin
               res_d.mask = 32'hFFFF_0000;
            end else if (!req_own_address[29]) begin
               res_d.mask = 32'hFFFF_FF00;
            end else begin
               res_d.mask = 32'd0;
            end
         end
         phase_in = PH_IDLE;
      end
   end

   // pack the results in order into one queue entry
   always_comb begin
      bundle      = '0;
      n           = '0;
      bundle.addr = req_own_address;
      if (a_v) begin
         bundle.res[n] = res_a;
         n = n + 1'b1;
      end
      if (b_v) begin
         bundle.res[n] = res_b;
         n = n + 1'b1;
      end
      if (c_v) begin
         bundle.res[n] = res_c;
         n = n + 1'b1;
      end
      if (d_v) begin
         bundle.res[n] = res_d;
         n = n + 1'b1;
      end
      bundle.count = n;
   end

   assign push.valid  = accept && (n != '0);
   assign push.bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COOKIE;
         cidx_ff  <= 2'd0;
         tag_ff   <= 8'd0;
         len_ff   <= 8'd0;
         off_ff   <= 8'd0;
         acc_ff   <= 32'd0;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cidx_ff  <= cidx_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
      end
   end

   `BVOP_ASSERT(a_data_offset_in_range, clock, reset, (phase_ff != PH_DATA) || (off_ff < len_ff))

endmodule

`default_nettype wire

@@ src/bvop_queue.sv @@
`default_nettype none
`include "bootp_vendor_option_parser_unit_assert.svh"

module bvop_queue
   import bvop_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output bundle_type       head,
   output queue_status_type q_status
);

   bundle_type         entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = count_ff == Q_CNT_W'(Q_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign head           = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.bundle;
      end
   end

   `BVOP_ASSERT(a_push_has_room, clock, reset, !push.valid || !q_status.full)
   `BVOP_ASSERT(a_pop_has_entry, clock, reset, !pop || !q_status.empty)
   `BVOP_ASSERT_NEXT(a_push_fills, clock, reset, do_push && !do_pop, !q_status.empty)

endmodule

`default_nettype wire

@@ src/bvop_back.sv @@
`default_nettype none
`include "bootp_vendor_option_parser_unit_assert.svh"

module bvop_back
   import bvop_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_option_tag,
   output logic [7:0]       rsp_option_length,
   output logic [7:0]       rsp_byte_offset,
   output logic [7:0]       rsp_option_byte,
   output logic             rsp_option_done,
   output logic [31:0]      rsp_net_mask,
   output logic [31:0]      rsp_network_addr,
   output logic [31:0]      rsp_broadcast_addr,
   output logic             rsp_last_result
);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              valid_ff, valid_in;
   result_type        res_ff;
   logic [31:0]       net_ff, bc_ff;
   logic              last_ff;

   result_type        cur;
   logic              load, last_slot;
   logic [31:0]       net, bc;

   assign cur       = head.res[slot_ff];
   assign last_slot = slot_ff == head.count - 1'b1;
   assign load      = !q_status.empty && (!valid_ff || !rsp_stall);
   assign pop       = load && last_slot;

   always_comb begin
      if (cur.kind == KIND_SUBNET || cur.kind == KIND_CLASSFUL) begin
         net = head.addr & cur.mask;
         bc  = net | ~cur.mask;
      end else begin
         net = 32'd0;
         bc  = 32'd0;
      end
      valid_in = load || (valid_ff && rsp_stall);
      slot_in  = slot_ff;
      if (load) begin
         slot_in = last_slot ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= cur;
         net_ff  <= net;
         bc_ff   <= bc;
         last_ff <= last_slot;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = res_ff.kind;
   assign rsp_option_tag     = res_ff.tag;
   assign rsp_option_length  = res_ff.len;
   assign rsp_byte_offset    = res_ff.offset;
   assign rsp_option_byte    = res_ff.data;
   assign rsp_option_done    = res_ff.done;
   assign rsp_net_mask       = res_ff.mask;
   assign rsp_network_addr   = net_ff;
   assign rsp_broadcast_addr = bc_ff;
   assign rsp_last_result    = last_ff;

   `BVOP_ASSERT(a_slot_rests_when_empty, clock, reset, !q_status.empty || (slot_ff == '0))

endmodule

`default_nettype wire

@@ src/bootp_vendor_option_parser_unit.sv @@
// BOOTP vendor area parser: feed the vendor area of a reply one byte per item,
// first_byte on its first byte and final_byte on its last, with the offered
// address. The block checks the magic cookie 99.130.83.99, then walks the
// tag-length-value options and gives out one result per option data byte,
// a subnet result (mask, network, broadcast) for a subnet-mask option of at
// least four bytes, a mismatch, end-tag or truncation report, and at the
// final byte a classful mask guess when no subnet result came for that area.
// The front accepts a byte every cycle while its four-entry result queue has
// room. Each item causes zero to three results, and the back end drains them
// at one result per cycle while rsp_stall is low, so sustained throughput is
// one byte per cycle for bytes with at most one result and slows where bytes
// cause more. A result passes the queue entry and the output register.
`default_nettype none

module bootp_vendor_option_parser_unit
   import bvop_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,
   input  logic [31:0] req_own_address,
   // result item channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_option_tag,
   output logic [7:0]  rsp_option_length,
   output logic [7:0]  rsp_byte_offset,
   output logic [7:0]  rsp_option_byte,
   output logic        rsp_option_done,
   output logic [31:0] rsp_net_mask,
   output logic [31:0] rsp_network_addr,
   output logic [31:0] rsp_broadcast_addr,
   output logic        rsp_last_result
);

   // front to queue: all results of one byte as one entry
   push_type         push;
   // queue to both sides
   queue_status_type q_status;
   bundle_type       head;
   logic             pop;

   // parser state machine, classifies each byte
   bvop_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_final_byte  (req_final_byte),
      .req_own_address (req_own_address),
      .q_status        (q_status),
      .push            (push)
   );

   // decouples the parser from output backpressure
   bvop_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // serializes entries, computes network and broadcast, holds the output register
   bvop_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_option_tag     (rsp_option_tag),
      .rsp_option_length  (rsp_option_length),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_option_byte    (rsp_option_byte),
      .rsp_option_done    (rsp_option_done),
      .rsp_net_mask       (rsp_net_mask),
      .rsp_network_addr   (rsp_network_addr),
      .rsp_broadcast_addr (rsp_broadcast_addr),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

`default_nettype wire

@@ sim/bootp_vendor_option_parser_unit_tb.sv @@
module bootp_vendor_option_parser_unit_tb;
   import bvop_pkg::*;

   // cycles with no item moving on either channel before the run is called hung
   localparam int QUIET_LIMIT  = 2000;
   // random part length, in vendor area bytes
   localparam int RANDOM_BYTES = 270;
   // settle time after the last expected result
   localparam int DRAIN_CYCLES = 20;

   // parser phases, mirrored from the block's behavior
   typedef enum logic [2:0] {
      ST_COOKIE,
      ST_TAG,
      ST_LEN,
      ST_DATA,
      ST_STOPPED,
      ST_IDLE
   } parse_phase_type;

   // one byte of a vendor area plus the idle cycles before it is offered
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        is_last;
      logic [31:0] addr;
      logic [4:0]  gap;
   } vendor_byte_type;

   // one result item as the block should give it out
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tag;
      logic [7:0]  len;
      logic [7:0]  offset;
      logic [7:0]  data;
      logic        done;
      logic [31:0] mask;
      logic [31:0] net;
      logic [31:0] bcast;
      logic        last;
   } parser_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        req_final_byte = 1'b0;
   logic [31:0] req_own_address = 32'd0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_option_tag;
   logic [7:0]  rsp_option_length;
   logic [7:0]  rsp_byte_offset;
   logic [7:0]  rsp_option_byte;
   logic        rsp_option_done;
   logic [31:0] rsp_net_mask;
   logic [31:0] rsp_network_addr;
   logic [31:0] rsp_broadcast_addr;
   logic        rsp_last_result;

   // bytes waiting to be offered, and results the parser still owes us
   vendor_byte_type   vendor_bytes_q[$];
   parser_result_type parser_results_q[$];

   // predictor copy of the parser state
   parse_phase_type phase_now    = ST_COOKIE;
   logic [1:0]   cookie_pos   = 2'd0;
   logic [7:0]   open_tag     = 8'd0;
   logic [7:0]   open_len     = 8'd0;
   logic [7:0]   data_pos     = 8'd0;
   logic [31:0]  mask_shift   = 32'd0;
   logic         subnet_given = 1'b0;

   int           mismatch_count = 0;
   int           result_count   = 0;
   int           queued_count   = 0;
   int           quiet_cycles   = 0;
   // idle style per side: 0 never waits, 1 waits now and then, 2 waits often
   int           send_mode      = 0;
   int           recv_mode      = 0;
   int           gap_spent      = 0;
   int           stall_left     = 0;
   vendor_byte_type next_byte;
   vendor_byte_type on_wire;

   bootp_vendor_option_parser_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_final_byte     (req_final_byte),
      .req_own_address    (req_own_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_option_tag     (rsp_option_tag),
      .rsp_option_length  (rsp_option_length),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_option_byte    (rsp_option_byte),
      .rsp_option_done    (rsp_option_done),
      .rsp_net_mask       (rsp_net_mask),
      .rsp_network_addr   (rsp_network_addr),
      .rsp_broadcast_addr (rsp_broadcast_addr),
      .rsp_last_result    (rsp_last_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // random wait length for one item, shaped by the side's idle style
   function automatic int draw_wait(input int mode);
      int cycles;
      cycles = 0;
      if (mode == 2 || (mode == 1 && $urandom_range(0, 3) == 0))
         cycles = $urandom_range(0, 17);
      return cycles;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // queue one expected result; address fields only carry meaning for mask results
   task automatic expect_result(input logic [2:0] kind, input logic [7:0] tag,
                                input logic [7:0] len, input logic [7:0] offset,
                                input logic [7:0] data, input logic done,
                                input logic [31:0] mask, input logic [31:0] addr);
      parser_result_type res;
      res.kind   = kind;
      res.tag    = tag;
      res.len    = len;
      res.offset = offset;
      res.data   = data;
      res.done   = done;
      res.mask   = 32'd0;
      res.net    = 32'd0;
      res.bcast  = 32'd0;
      res.last   = 1'b0;
      if (kind == KIND_SUBNET || kind == KIND_CLASSFUL) begin
         res.mask  = mask;
         res.net   = addr & mask;
         res.bcast = (addr & mask) | ~mask;
      end
      parser_results_q.push_back(res);
   endtask

   // advance the predicted parser by one accepted byte and queue what it gives out
   task automatic parse_vendor_byte(input vendor_byte_type vb);
      int             n_before;
      logic           finishing;
      logic [31:0]    guess;
      parser_result_type tail;
      n_before = parser_results_q.size();
      // a new area restarts everything before the byte is looked at
      if (vb.first) begin
         phase_now    = ST_COOKIE;
         cookie_pos   = 2'd0;
         open_tag     = 8'd0;
         open_len     = 8'd0;
         data_pos     = 8'd0;
         mask_shift   = 32'd0;
         subnet_given = 1'b0;
      end
      // once the final byte has gone by, nothing counts until the next area
      if (phase_now != ST_IDLE) begin
         case (phase_now)
            ST_COOKIE: begin
               if (vb.data != COOKIE_BYTES[cookie_pos]) begin
                  expect_result(KIND_MISMATCH, 8'd0, 8'd0, {6'd0, cookie_pos}, vb.data,
                                1'b0, 32'd0, 32'd0);
                  phase_now = ST_STOPPED;
               end else if (cookie_pos == 2'd3) begin
                  cookie_pos = 2'd0;
                  phase_now  = ST_TAG;
               end else begin
                  cookie_pos = cookie_pos + 2'd1;
               end
            end
            ST_TAG: begin
               if (vb.data == TAG_END) begin
                  expect_result(KIND_END, TAG_END, 8'd0, 8'd0, 8'd0, 1'b0, 32'd0, 32'd0);
                  phase_now = ST_STOPPED;
               end else if (vb.data != TAG_PAD) begin
                  open_tag  = vb.data;
                  open_len  = 8'd0;
                  data_pos  = 8'd0;
                  phase_now = ST_LEN;
               end
            end
            ST_LEN: begin
               open_len   = vb.data;
               data_pos   = 8'd0;
               mask_shift = 32'd0;
               phase_now  = (vb.data == 8'd0) ? ST_TAG : ST_DATA;
            end
            ST_DATA: begin
               finishing = ({1'b0, data_pos} + 9'd1 == {1'b0, open_len});
               expect_result(KIND_DATA, open_tag, open_len, data_pos, vb.data, finishing,
                             32'd0, 32'd0);
               // only the first four bytes of a subnet option make up the mask
               if (open_tag == TAG_SUBNET && data_pos < 8'd4)
                  mask_shift = {mask_shift[23:0], vb.data};
               if (finishing) begin
                  if (open_tag == TAG_SUBNET && open_len >= 8'd4) begin
                     expect_result(KIND_SUBNET, TAG_SUBNET, open_len, 8'd0, 8'd0, 1'b0,
                                   mask_shift, vb.addr);
                     subnet_given = 1'b1;
                  end
                  phase_now = ST_TAG;
               end else begin
                  data_pos = data_pos + 8'd1;
               end
            end
            default: begin
            end
         endcase

         if (vb.is_last) begin
            // area cut short inside the cookie, after a tag or inside option data
            case (phase_now)
               ST_COOKIE: expect_result(KIND_TRUNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                        32'd0, 32'd0);
               ST_LEN:    expect_result(KIND_TRUNC, open_tag, 8'd0, 8'd0, 8'd0, 1'b0,
                                        32'd0, 32'd0);
               ST_DATA:   expect_result(KIND_TRUNC, open_tag, open_len, data_pos, 8'd0,
                                        1'b0, 32'd0, 32'd0);
               default: begin
               end
            endcase
            // no mask option seen: fall back on the address class
            if (!subnet_given) begin
               if (!vb.addr[31])
                  guess = 32'hFF000000;
               else if (!vb.addr[30])
                  guess = 32'hFFFF0000;
               else if (!vb.addr[29])
                  guess = 32'hFFFFFF00;
               else
                  guess = 32'h00000000;
               expect_result(KIND_CLASSFUL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, guess, vb.addr);
            end
            phase_now = ST_IDLE;
         end
      end
      // flag the closing result of this byte
      if (parser_results_q.size() > n_before) begin
         tail = parser_results_q.pop_back();
         tail.last = 1'b1;
         parser_results_q.push_back(tail);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   result_count, field, got, want));
   endtask

   // compare the result on the channel with the oldest one owed
   task automatic check_result();
      parser_result_type want;
      if (parser_results_q.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with none owed, kind %0d",
                                   result_count, rsp_kind));
      end else begin
         want = parser_results_q.pop_front();
         check_field("kind", 32'(rsp_kind), 32'(want.kind));
         check_field("option_tag", 32'(rsp_option_tag), 32'(want.tag));
         check_field("option_length", 32'(rsp_option_length), 32'(want.len));
         check_field("byte_offset", 32'(rsp_byte_offset), 32'(want.offset));
         check_field("option_byte", 32'(rsp_option_byte), 32'(want.data));
         check_field("option_done", 32'(rsp_option_done), 32'(want.done));
         check_field("net_mask", rsp_net_mask, want.mask);
         check_field("network_addr", rsp_network_addr, want.net);
         check_field("broadcast_addr", rsp_broadcast_addr, want.bcast);
         check_field("last_result", 32'(rsp_last_result), 32'(want.last));
      end
      result_count++;
   endtask

   task automatic add_byte(input logic [7:0] data, input logic first, input logic is_last,
                           input logic [31:0] addr);
      vendor_byte_type vb;
      vb.data    = data;
      vb.first   = first;
      vb.is_last = is_last;
      vb.addr    = addr;
      vb.gap     = 5'(draw_wait(send_mode));
      vendor_bytes_q.push_back(vb);
      queued_count++;
   endtask

   // one random vendor area: mostly well-formed option lists with random content,
   // the rest broken cookies, short cookies, stray bytes and noise
   task automatic build_random_area();
      logic [7:0]  area_q[$];
      logic [7:0]  octet;
      logic [31:0] addr;
      int          shape;
      int          n_opt;
      int          opt_len;
      int          n_emit;
      int          j;
      int          k;
      addr = $urandom;
      // steer the top bits so every address class shows up
      case ($urandom_range(0, 3))
         0: addr[31] = 1'b0;
         1: addr[31:30] = 2'b10;
         2: addr[31:29] = 3'b110;
         default: addr[31:29] = 3'b111;
      endcase
      send_mode = $urandom_range(0, 2);
      shape = $urandom_range(0, 99);
      for (j = 0; j < 4; j++)
         area_q.push_back(COOKIE_BYTES[j]);

      if (shape < 80) begin
         n_opt = $urandom_range(1, 4);
         for (j = 0; j < n_opt; j++) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
               area_q.push_back(TAG_PAD);
            end else begin
               if (k <= 3) begin
                  area_q.push_back(TAG_SUBNET);
                  // short subnet options now and then
                  opt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(4, 6);
               end else begin
                  octet = 8'($urandom_range(2, 254));
                  area_q.push_back(octet);
                  opt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                        : $urandom_range(0, 8);
               end
               octet = 8'(opt_len);
               area_q.push_back(octet);
               for (k = 0; k < opt_len; k++) begin
                  octet = 8'($urandom);
                  area_q.push_back(octet);
               end
            end
         end
         // how the area closes: end tag, end tag plus trailing bytes,
         // final on the last option byte, or cut off somewhere inside
         k = $urandom_range(0, 3);
         if (k == 0) begin
            area_q.push_back(TAG_END);
         end else if (k == 1) begin
            area_q.push_back(TAG_END);
            repeat ($urandom_range(1, 3)) begin
               octet = 8'($urandom);
               area_q.push_back(octet);
            end
         end
         n_emit = area_q.size();
         if (k == 3)
            n_emit = $urandom_range(5, area_q.size());
      end else if (shape < 90) begin
         // corrupt one cookie byte, then some bytes that must be ignored
         k = $urandom_range(0, 3);
         octet = 8'($urandom_range(1, 255));
         area_q[k] = area_q[k] ^ octet;
         repeat ($urandom_range(0, 4)) begin
            octet = 8'($urandom);
            area_q.push_back(octet);
         end
         n_emit = area_q.size();
      end else begin
         // area ends before the cookie is complete
         n_emit = $urandom_range(1, 3);
      end

      for (j = 0; j < n_emit; j++)
         add_byte(area_q[j], j == 0, j == n_emit - 1, addr);

      // a stray byte after the final one, which the parser must ignore
      if ($urandom_range(0, 9) == 0)
         add_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), $urandom);
      // bursts of noise with random marks
      if ($urandom_range(0, 14) == 0)
         repeat ($urandom_range(1, 6))
            add_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                     $urandom);
   endtask

   // driver: offers queued bytes, honoring each byte's idle gap, and feeds every
   // accepted byte to the predictor at the edge where it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_spent = 0;
      end else begin
         if (req_valid && !req_stall)
            parse_vendor_byte(on_wire);
         // the slot is free unless a stalled byte is still on the wire
         if (!req_valid || !req_stall) begin
            if (vendor_bytes_q.size() != 0)
               next_byte = vendor_bytes_q[0];
            if (vendor_bytes_q.size() != 0 && gap_spent >= next_byte.gap) begin
               on_wire = vendor_bytes_q.pop_front();
               req_data_byte   <= on_wire.data;
               req_first_byte  <= on_wire.first;
               req_final_byte  <= on_wire.is_last;
               req_own_address <= on_wire.addr;
               req_valid       <= 1'b1;
               gap_spent = 0;
            end else begin
               req_valid <= 1'b0;
               if (vendor_bytes_q.size() != 0)
                  gap_spent++;
            end
         end
      end
   end

   // monitor: checks each accepted result, then draws how long to stall
   // before taking the next one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
            if ($urandom_range(0, 39) == 0)
               recv_mode = $urandom_range(0, 2);
            stall_left = draw_wait(recv_mode);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog: a long stretch with no item moving either way means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      parser_result_type leftover;
      int             directed_count;

      // good area: cookie, full subnet option, end tag on the final byte;
      // subnet result suppresses the classful guess
      send_mode = 0;
      add_byte(8'd99, 1'b1, 1'b0, 32'hC0A80105);
      add_byte(8'd130, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'd83, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'd99, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(TAG_SUBNET, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'd4, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'hFF, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'hFF, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'hFF, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(8'h00, 1'b0, 1'b0, 32'hC0A80105);
      add_byte(TAG_END, 1'b0, 1'b1, 32'hC0A80105);

      // cookie mismatch on the third byte, then the final byte only guesses
      send_mode = 2;
      add_byte(8'd99, 1'b1, 1'b0, 32'h00000000);
      add_byte(8'd130, 1'b0, 1'b0, 32'h00000000);
      add_byte(8'd0, 1'b0, 1'b0, 32'h00000000);
      add_byte(8'hFF, 1'b0, 1'b1, 32'h00000000);
      // byte after the final one without a new area mark: ignored
      add_byte(8'h12, 1'b0, 1'b1, 32'hFFFFFFFF);

      // area that ends inside the cookie
      add_byte(8'd99, 1'b1, 1'b0, 32'h80000000);
      add_byte(8'd130, 1'b0, 1'b1, 32'h80000000);

      // pad, zero-length option, short subnet option, then a cut-off option:
      // the last byte gives data, truncation and the all-zero classful mask
      send_mode = 1;
      add_byte(8'd99, 1'b1, 1'b0, 32'hE0000000);
      add_byte(8'd130, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd83, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd99, 1'b0, 1'b0, 32'hE0000000);
      add_byte(TAG_PAD, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd7, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd0, 1'b0, 1'b0, 32'hE0000000);
      add_byte(TAG_SUBNET, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd2, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'hAA, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'hBB, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd254, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'd3, 1'b0, 1'b0, 32'hE0000000);
      add_byte(8'h5A, 1'b0, 1'b1, 32'hE0000000);

      directed_count = queued_count;
      while (queued_count < directed_count + RANDOM_BYTES)
         build_random_area();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // everything offered, taken, and every owed result seen
      while (vendor_bytes_q.size() != 0 || req_valid || parser_results_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      while (parser_results_q.size() != 0) begin
         leftover = parser_results_q.pop_front();
         report_mismatch($sformatf("owed result of kind %0d never came", leftover.kind));
      end

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
